/* sv/wapcd_pkg.sv */
// Package for the wrapped-angle PD cable drive: sizes, constants, FSM codes, saturation.
`default_nettype none

package wapcd_pkg;

  localparam int NUM_JOINTS = 32;
  localparam int JOINT_AW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // Q4.12 angle constants
  localparam logic signed [16:0] ERR_HI = 17'sd12868;
  localparam logic signed [16:0] ERR_LO = -17'sd12868;
  localparam logic signed [16:0] TWO_PI = 17'sd25736;

  localparam logic [19:0] DERIV_SCALE = 20'd1000000;

  // kd * |diff| is 33 bits, times the 20-bit scale gives the dividend
  localparam int MAG_W  = 33;
  localparam int PROD_W = MAG_W + 20;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int SUM_W  = PROD_W + 3;

  localparam logic signed [SUM_W-1:0] DRV_RND  = SUM_W'(8);
  localparam logic signed [63:0]      RATE_RND = 64'sd2048;
  localparam logic signed [63:0]      SAT_MAX  = 64'sd2147483647;
  localparam logic signed [63:0]      SAT_MIN  = -64'sd2147483648;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WRAP  = 8'b0000_0010,
    S_MUL1  = 8'b0000_0100,
    S_MUL2  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_DRIVE = 8'b0010_0000,
    S_RATE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    if (x > SAT_MAX) begin
      r.val  = 32'sh7fff_ffff;
      r.clip = 1'b1;
    end else if (x < SAT_MIN) begin
      r.val  = 32'sh8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = x[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/wapcd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wapcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/wrapped_angle_pd_cable_drive.sv */
// Flow: an accepted word first wraps its error into range in S_WRAP, then forms its product
// and rounded rate; a first word of a joint step also computes the drive before that.
// A new word is taken only in idle, after the last result is handed to the output; the drive
// is set by the bit-serial divider, one quotient bit of 53 per cycle.
// Reset clears the FSM, the output valid, the held drive and the per-joint valid bits;
// a joint's stored error reads as zero until written, so no clearing pass is needed.
`default_nettype none

module wrapped_angle_pd_cable_drive (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [4:0]         joint_index_i,
  input  wire logic signed [15:0] measured_angle_i,
  input  wire logic signed [15:0] target_angle_i,
  input  wire logic [19:0]        period_us_i,
  input  wire logic [15:0]        prop_gain_i,
  input  wire logic [15:0]        deriv_gain_i,
  input  wire logic signed [15:0] cable_coef_i,
  input  wire logic               first_cable_i,
  input  wire logic               last_cable_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      cable_rate_o,
  output logic                    saturated_o,
  output logic                    last_of_joint_o
);

  import wapcd_pkg::*;

  state_e state_q, state_d;

  logic [JOINT_AW-1:0]   addr_q, addr_in;
  logic [JOINT_AW+4:0]   joint_ext;
  logic                  inr_q, inr_in;
  logic                  first_q, last_q;
  logic [15:0]           kp_q, kd_q;
  logic signed [15:0]    coef_q;
  logic [19:0]           div_q;
  logic signed [16:0]    d_q, d_d;
  logic                  pvld_q;
  logic [MAG_W-1:0]      m1_q;
  logic                  neg_q;
  logic signed [32:0]    kpe_q;
  logic [PROD_W-1:0]     q_q, q_d;
  logic [19:0]           rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [31:0]    held_drive_q, held_drive_d;
  logic                  held_clip_q, held_clip_d;
  logic signed [47:0]    prod_q;
  logic                  out_valid_q, out_valid_d;
  logic signed [31:0]    rate_q;
  logic                  sat_q, last_out_q;
  logic [NUM_JOINTS-1:0] vld_q;

  logic                  accept, out_free, ram_we, wrap_hi, wrap_lo;
  logic [15:0]           ram_rdata;
  logic signed [15:0]    err_s, prev_s;
  logic signed [16:0]    diff_s;
  logic [16:0]           diff_mag;
  logic [20:0]           r_sh;
  logic                  r_ge;
  logic signed [SUM_W-1:0] q_s, drv_sum, drv_sh;
  logic signed [63:0]    rate_sh;
  sat_t                  drv_sat, rate_sat;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign joint_ext = {{JOINT_AW{1'b0}}, joint_index_i};
  assign addr_in   = joint_ext[JOINT_AW-1:0];
  assign inr_in    = 32'(joint_index_i) < NUM_JOINTS;

  assign wrap_hi = d_q >= ERR_HI;
  assign wrap_lo = d_q < ERR_LO;

  assign err_s    = d_q[15:0];
  assign prev_s   = pvld_q ? ram_rdata : 16'h0000;
  assign diff_s   = 17'(err_s) - 17'(prev_s);
  assign diff_mag = diff_s[16] ? 17'(-diff_s) : 17'(diff_s);

  // restoring divide step
  assign r_sh = {rem_q, q_q[PROD_W-1]};
  assign r_ge = r_sh >= {1'b0, div_q};

  assign q_s     = neg_q ? -$signed(SUM_W'(q_q)) : $signed(SUM_W'(q_q));
  assign drv_sum = q_s + SUM_W'(kpe_q) + DRV_RND;
  assign drv_sh  = drv_sum >>> 4;
  assign drv_sat = sat32(64'(drv_sh));

  assign rate_sh  = (64'(prod_q) + RATE_RND) >>> 12;
  assign rate_sat = sat32(rate_sh);

  assign ram_we = (state_q == S_OUT) && out_free && last_q && inr_q;

  wapcd_ram #(
    .WIDTH(16),
    .DEPTH(NUM_JOINTS)
  ) u_prev_err (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(d_q[15:0]),
    .re_i   (accept),
    .raddr_i(addr_in),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    d_d          = d_q;
    q_d          = q_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    held_drive_d = held_drive_q;
    held_clip_d  = held_clip_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          d_d     = 17'(measured_angle_i) - 17'(target_angle_i);
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (wrap_hi) begin
          d_d = d_q - TWO_PI;
        end else if (wrap_lo) begin
          d_d = d_q + TWO_PI;
        end else begin
          state_d = first_q ? S_MUL1 : S_RATE;
        end
      end
      S_MUL1: begin
        state_d = S_MUL2;
      end
      S_MUL2: begin
        q_d     = PROD_W'(m1_q) * PROD_W'(DERIV_SCALE);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = r_ge ? 20'(r_sh - {1'b0, div_q}) : r_sh[19:0];
        q_d   = {q_q[PROD_W-2:0], r_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          state_d = S_DRIVE;
        end
      end
      S_DRIVE: begin
        held_drive_d = drv_sat.val;
        held_clip_d  = drv_sat.clip;
        state_d      = S_RATE;
      end
      S_RATE: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      held_drive_q <= '0;
      held_clip_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      vld_q        <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      held_drive_q <= held_drive_d;
      held_clip_q  <= held_clip_d;
      out_valid_q  <= out_valid_d;
      if (ram_we) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    if (accept) begin
      addr_q  <= addr_in;
      inr_q   <= inr_in;
      pvld_q  <= inr_in && vld_q[addr_in];
      first_q <= first_cable_i;
      last_q  <= last_cable_i;
      kp_q    <= prop_gain_i;
      kd_q    <= deriv_gain_i;
      coef_q  <= cable_coef_i;
      div_q   <= (period_us_i == 20'd0) ? 20'd1 : period_us_i;
    end
    if (state_q == S_MUL1) begin
      m1_q  <= MAG_W'(kd_q) * MAG_W'(diff_mag);
      neg_q <= diff_s[16];
      kpe_q <= 33'($signed({1'b0, kp_q})) * 33'(err_s);
    end
    if (state_q == S_RATE) begin
      prod_q <= 48'(coef_q) * 48'(held_drive_q);
    end
    if ((state_q == S_OUT) && out_free) begin
      rate_q     <= rate_sat.val;
      sat_q      <= rate_sat.clip || held_clip_q;
      last_out_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cable_rate_o    = rate_q;
  assign saturated_o     = sat_q;
  assign last_of_joint_o = last_out_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_q != 20'd0))
    else $error("divisor is zero during divide");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= CNT_W'(PROD_W - 1)))
    else $error("divide counter ran past the last bit");

  a_store_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_OUT) && last_q && inr_q)
    else $error("error stored outside the last word of a joint");

  a_out_from_fsm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("output valid raised outside the output state");
`endif

endmodule

`default_nettype wire
